@@ sv/vfc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types and constants for the V/f curve voltage command block.
// ----------------------------------------------------------------------------
package vfc_pkg;

    localparam int FREQ_W  = 17;
    localparam int VOLT_W  = 16;
    localparam int NUM_W   = 32;
    localparam int QUO_W   = 16;
    localparam int CIDX_W  = 3;
    localparam int CDAT_W  = 32;
    localparam int KNEES   = 5;

    typedef enum logic [CIDX_W-1:0] {
        REG_CURVE_MODE = 3'd0,
        REG_MAG_VOLT   = 3'd1,
        REG_KNEE_ONE   = 3'd2,
        REG_KNEE_TWO   = 3'd3,
        REG_KNEE_THREE = 3'd4,
        REG_SAT_KNEE   = 3'd5,
        REG_NOM_VOLT   = 3'd6
    } reg_idx_t;

    localparam logic [31:0] SAT_KNEE_RST = 32'd327683800;
    localparam logic [15:0] NOM_VOLT_RST = 16'd3800;

    typedef struct packed {
        logic        curve_mode;
        logic [15:0] mag_volt;
        logic [31:0] knee_one;
        logic [31:0] knee_two;
        logic [31:0] knee_three;
        logic [31:0] sat_knee;
    } curve_cfg_t;

endpackage : vfc_pkg
`default_nettype wire

@@ sv/vfc_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vfc_div
// Pipelined restoring divider, one quotient bit per stage. The caller keeps
// the dividend below divisor * 2^QUO_W so the quotient fits.
// ----------------------------------------------------------------------------
module vfc_div #(
    parameter int SBW = 18
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [vfc_pkg::NUM_W-1:0] in_num,
    input  wire logic [15:0]               in_den,
    input  wire logic [SBW-1:0]            in_sb,
    output logic                           out_valid,
    output logic [vfc_pkg::QUO_W-1:0]      out_quo,
    output logic [SBW-1:0]                 out_sb
);

    localparam int Q = vfc_pkg::QUO_W;
    localparam int W = vfc_pkg::NUM_W;

    logic         vld_reg [Q];
    logic [W-1:0] rem_reg [Q];
    logic [15:0]  den_reg [Q];
    logic [Q-1:0] quo_reg [Q];
    logic [SBW-1:0] sb_reg [Q];

    genvar i;
    generate
        for (i = 0; i < Q; i++) begin : g_stage
            logic         vld_src;
            logic [W-1:0] rem_src;
            logic [15:0]  den_src;
            logic [Q-1:0] quo_src;
            logic [SBW-1:0] sb_src;
            logic [W:0]   trial;
            logic [W-1:0] rem_next;
            logic [Q-1:0] quo_next;

            if (i == 0) begin : g_first
                assign vld_src = in_valid;
                assign rem_src = in_num;
                assign den_src = in_den;
                assign quo_src = '0;
                assign sb_src  = in_sb;
            end else begin : g_rest
                assign vld_src = vld_reg[i-1];
                assign rem_src = rem_reg[i-1];
                assign den_src = den_reg[i-1];
                assign quo_src = quo_reg[i-1];
                assign sb_src  = sb_reg[i-1];
            end

            // Try subtracting the shifted divisor for this bit
            always_comb begin
                trial    = {1'b0, rem_src} - ({{(W+1-16){1'b0}}, den_src} << (Q-1-i));
                rem_next = rem_src;
                quo_next = quo_src;
                if (!trial[W]) begin
                    rem_next        = trial[W-1:0];
                    quo_next[Q-1-i] = 1'b1;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[i] <= 1'b0;
                end else if (en) begin
                    vld_reg[i] <= vld_src;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= rem_next;
                    den_reg[i] <= den_src;
                    quo_reg[i] <= quo_next;
                    sb_reg[i]  <= sb_src;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[Q-1];
    assign out_quo   = quo_reg[Q-1];
    assign out_sb    = sb_reg[Q-1];

endmodule : vfc_div
`default_nettype wire

@@ sv/vfc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vfc_front
// Front stage: takes the frequency magnitude, picks the curve segment and
// registers the interpolation terms. Constant results become a zero product.
// ----------------------------------------------------------------------------
module vfc_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [vfc_pkg::FREQ_W-1:0] freq,
    input  wire vfc_pkg::curve_cfg_t        cfg,
    output logic                            out_valid,
    output logic [16:0]                     df_reg,
    output logic signed [16:0]              dv_reg,
    output logic [15:0]                     den_reg,
    output logic [15:0]                     va_reg,
    output logic                            fb_reg
);

    logic [16:0] f;
    logic [15:0] kf [vfc_pkg::KNEES];
    logic [15:0] kv [vfc_pkg::KNEES];
    logic        degen;
    logic [2:0]  seg;
    logic        hit;
    logic [16:0] df_next;
    logic signed [16:0] dv_next;
    logic [15:0] den_next;
    logic [15:0] va_next;
    logic        fb_next;
    logic        vld_reg;

    always_comb begin
        kf[0] = '0;                  kv[0] = cfg.mag_volt;
        kf[1] = cfg.knee_one[31:16];   kv[1] = cfg.knee_one[15:0];
        kf[2] = cfg.knee_two[31:16];   kv[2] = cfg.knee_two[15:0];
        kf[3] = cfg.knee_three[31:16]; kv[3] = cfg.knee_three[15:0];
        kf[4] = cfg.sat_knee[31:16];   kv[4] = cfg.sat_knee[15:0];
    end

    // Magnitude and segment search, first knee above f wins
    always_comb begin
        f     = freq[16] ? (17'd0 - freq) : freq;
        degen = 1'b0;
        seg   = 3'd0;
        hit   = 1'b0;
        for (int k = vfc_pkg::KNEES - 2; k >= 0; k--) begin
            if (kf[k+1] == kf[k]) degen = 1'b1;
            if (f < {1'b0, kf[k+1]}) begin
                seg = 3'(k);
                hit = 1'b1;
            end
        end
    end

    // Build numerator factors, divisor and base voltage
    always_comb begin
        df_next  = '0;
        dv_next  = '0;
        den_next = 16'd1;
        va_next  = kv[4];
        fb_next  = 1'b0;
        if (cfg.curve_mode && !degen) begin
            if (f == '0) begin
                va_next = '0;
            end else if (hit) begin
                df_next  = f - {1'b0, kf[seg]};
                dv_next  = $signed({1'b0, kv[seg+3'd1]}) - $signed({1'b0, kv[seg]});
                den_next = kf[seg+3'd1] - kf[seg];
                va_next  = kv[seg];
            end
        end else begin
            fb_next = cfg.curve_mode;
            if (kf[4] != '0 && f <= {1'b0, kf[4]}) begin
                df_next  = f;
                dv_next  = $signed({1'b0, kv[4]});
                den_next = kf[4];
                va_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            df_reg  <= df_next;
            dv_reg  <= dv_next;
            den_reg <= den_next;
            va_reg  <= va_next;
            fb_reg  <= fb_next;
        end
    end

    assign out_valid = vld_reg;

endmodule : vfc_front
`default_nettype wire

@@ sv/vf_curve_voltage_command.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vf_curve_voltage_command
// V/f curve voltage command: frequency magnitude to voltage and PWM level.
// ----------------------------------------------------------------------------
// Pipeline: front stage, multiply, magnitude, 16-stage curve divider, voltage,
// PWM multiply, PWM range check, 16-stage PWM divider, output register.
// Throughput: one beat per cycle; the whole pipeline holds while a result
// waits at the output.
// Reset: synchronous active-low aresetn clears valid bits and loads the
// register defaults.
// ----------------------------------------------------------------------------
module vf_curve_voltage_command #(
    parameter int PWM_FULL_SCALE = 7400
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [16:0] freq_command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] voltage_out, [31:16] pwm_level
    output logic             m_tuser,   // [0] curve_fallback
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [vfc_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [vfc_pkg::CDAT_W-1:0] cfg_data
);

    localparam logic [15:0] PWM_FS = 16'(PWM_FULL_SCALE);

    vfc_pkg::curve_cfg_t cfg_reg;
    logic [15:0]         nom_reg;
    logic                en;

    // Configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.curve_mode <= 1'b0;
            cfg_reg.mag_volt   <= '0;
            cfg_reg.knee_one   <= '0;
            cfg_reg.knee_two   <= '0;
            cfg_reg.knee_three <= '0;
            cfg_reg.sat_knee   <= vfc_pkg::SAT_KNEE_RST;
            nom_reg            <= vfc_pkg::NOM_VOLT_RST;
        end else if (cfg_valid) begin
            case (vfc_pkg::reg_idx_t'(cfg_index))
                vfc_pkg::REG_CURVE_MODE: cfg_reg.curve_mode <= cfg_data[0];
                vfc_pkg::REG_MAG_VOLT:   cfg_reg.mag_volt   <= cfg_data[15:0];
                vfc_pkg::REG_KNEE_ONE:   cfg_reg.knee_one   <= cfg_data;
                vfc_pkg::REG_KNEE_TWO:   cfg_reg.knee_two   <= cfg_data;
                vfc_pkg::REG_KNEE_THREE: cfg_reg.knee_three <= cfg_data;
                vfc_pkg::REG_SAT_KNEE:   cfg_reg.sat_knee   <= cfg_data;
                vfc_pkg::REG_NOM_VOLT:   nom_reg            <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Advance every stage unless the output beat is held
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Front stage
    logic               f_vld;
    logic [16:0]        f_df;
    logic signed [16:0] f_dv;
    logic [15:0]        f_den;
    logic [15:0]        f_va;
    logic               f_fb;

    vfc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .freq      (s_tdata[16:0]),
        .cfg       (cfg_reg),
        .out_valid (f_vld),
        .df_reg    (f_df),
        .dv_reg    (f_dv),
        .den_reg   (f_den),
        .va_reg    (f_va),
        .fb_reg    (f_fb)
    );

    // Interpolation product
    logic               mul_vld_reg;
    logic signed [34:0] prod_reg;
    logic [15:0]        mul_den_reg;
    logic [15:0]        mul_va_reg;
    logic               mul_fb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
        end else if (en) begin
            mul_vld_reg <= f_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg    <= $signed({1'b0, f_df}) * f_dv;
            mul_den_reg <= f_den;
            mul_va_reg  <= f_va;
            mul_fb_reg  <= f_fb;
        end
    end

    // Split sign and magnitude so the quotient truncates toward zero
    logic        mag_vld_reg;
    logic [31:0] mag_reg;
    logic [15:0] mag_den_reg;
    logic [17:0] mag_sb_reg;
    logic [34:0] prod_abs;

    assign prod_abs = prod_reg[34] ? 35'(-prod_reg) : 35'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_vld_reg <= 1'b0;
        end else if (en) begin
            mag_vld_reg <= mul_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg     <= prod_abs[31:0];
            mag_den_reg <= mul_den_reg;
            mag_sb_reg  <= {mul_fb_reg, prod_reg[34], mul_va_reg};
        end
    end

    // Curve division
    logic        cd_vld;
    logic [15:0] cd_quo;
    logic [17:0] cd_sb;

    vfc_div #(.SBW(18)) u_curve_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mag_vld_reg),
        .in_num    (mag_reg),
        .in_den    (mag_den_reg),
        .in_sb     (mag_sb_reg),
        .out_valid (cd_vld),
        .out_quo   (cd_quo),
        .out_sb    (cd_sb)
    );

    // Apply the signed step and clamp the voltage
    logic               v_vld_reg;
    logic [15:0]        v_reg;
    logic               v_fb_reg;
    logic signed [17:0] v_sum;
    logic [15:0]        v_next;

    always_comb begin
        if (cd_sb[16]) begin
            v_sum = $signed({2'b00, cd_sb[15:0]}) - $signed({2'b00, cd_quo});
        end else begin
            v_sum = $signed({2'b00, cd_sb[15:0]}) + $signed({2'b00, cd_quo});
        end
        if (v_sum < 0) begin
            v_next = '0;
        end else if (v_sum > 18'sd65535) begin
            v_next = 16'hFFFF;
        end else begin
            v_next = v_sum[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_vld_reg <= 1'b0;
        end else if (en) begin
            v_vld_reg <= cd_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg    <= v_next;
            v_fb_reg <= cd_sb[17];
        end
    end

    // Scale by the PWM full scale
    logic        pm_vld_reg;
    logic [31:0] pm_reg;
    logic [15:0] pm_v_reg;
    logic        pm_fb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pm_vld_reg <= 1'b0;
        end else if (en) begin
            pm_vld_reg <= v_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pm_reg    <= v_reg * PWM_FS;
            pm_v_reg  <= v_reg;
            pm_fb_reg <= v_fb_reg;
        end
    end

    // Range check: zero nominal gives full scale, large quotients saturate
    logic        pr_vld_reg;
    logic [31:0] pr_num_reg;
    logic [15:0] pr_den_reg;
    logic [17:0] pr_sb_reg;
    logic [31:0] pr_num_next;
    logic [15:0] pr_den_next;
    logic        pr_sat_next;

    always_comb begin
        pr_num_next = pm_reg;
        pr_den_next = nom_reg;
        pr_sat_next = 1'b0;
        if (nom_reg == '0) begin
            pr_num_next = {16'd0, PWM_FS};
            pr_den_next = 16'd1;
        end else if (pm_reg[31:16] >= nom_reg) begin
            pr_num_next = '0;
            pr_sat_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pr_vld_reg <= 1'b0;
        end else if (en) begin
            pr_vld_reg <= pm_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pr_num_reg <= pr_num_next;
            pr_den_reg <= pr_den_next;
            pr_sb_reg  <= {pm_fb_reg, pr_sat_next, pm_v_reg};
        end
    end

    // PWM division
    logic        pd_vld;
    logic [15:0] pd_quo;
    logic [17:0] pd_sb;

    vfc_div #(.SBW(18)) u_pwm_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pr_vld_reg),
        .in_num    (pr_num_reg),
        .in_den    (pr_den_reg),
        .in_sb     (pr_sb_reg),
        .out_valid (pd_vld),
        .out_quo   (pd_quo),
        .out_sb    (pd_sb)
    );

    // Output register
    logic        out_vld_reg;
    logic [31:0] out_data_reg;
    logic        out_fb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= pd_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {(pd_sb[16] ? 16'hFFFF : pd_quo), pd_sb[15:0]};
            out_fb_reg   <= pd_sb[17];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_fb_reg;

endmodule : vf_curve_voltage_command
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the V/f curve voltage command block. Frequency commands
// are sent under random idling on both sides; each result beat is compared
// against a behavioural curve and PWM calculation kept alongside the shadow
// register settings, across simple, piecewise and fallback curve setups.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PWM_FS  = 7400;
    localparam int LATENCY = 39;

    typedef struct {
        logic [15:0] volt;
        logic [15:0] pwm;
        logic        fallback;
    } vcmd_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    wire logic   s_tready;
    logic [23:0] s_tdata;
    wire logic   m_tvalid;
    logic        m_tready;
    wire logic [31:0] m_tdata;
    wire logic   m_tuser;
    logic        cfg_valid;
    wire logic   cfg_ready;
    logic [vfc_pkg::CIDX_W-1:0] cfg_index;
    logic [vfc_pkg::CDAT_W-1:0] cfg_data;

    // shadow copy of the block's registers
    logic        sh_mode;
    logic [15:0] sh_mag;
    logic [31:0] sh_knee [1:4];
    logic [15:0] sh_nom;

    vcmd_t pending_cmds [$];
    int    n_errors;
    int    n_checked;
    int    n_sent;
    bit    quiet_mode;
    int    hold_cycles;

    vf_curve_voltage_command dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200000000;
        $display("Timeout at %0t", $time);
        $display("Mismatches found");
        $finish;
    end

    // Work out the voltage command for one frequency beat
    function automatic vcmd_t predict_vcmd(logic [16:0] fcmd);
        longint f, v, pwm, num;
        longint kf [0:4];
        longint kv [0:4];
        bit     degen;
        int     seg;
        vcmd_t  r;
        f = $signed(fcmd);
        if (f < 0) f = -f;
        kf[0] = 0;
        kv[0] = sh_mag;
        for (int i = 1; i <= 4; i++) begin
            kf[i] = sh_knee[i][31:16];
            kv[i] = sh_knee[i][15:0];
        end
        degen = 0;
        for (int i = 0; i < 4; i++) if (kf[i+1] == kf[i]) degen = 1;
        r.fallback = sh_mode && degen;
        if (sh_mode && !degen) begin
            if (f == 0) begin
                v = 0;
            end else begin
                seg = 4;
                for (int i = 3; i >= 0; i--) if (f < kf[i+1]) seg = i;
                if (seg == 4) begin
                    v = kv[4];
                end else begin
                    num = (f - kf[seg]) * (kv[seg+1] - kv[seg]);
                    v = kv[seg] + num / (kf[seg+1] - kf[seg]);
                end
            end
        end else if (f > kf[4] || kf[4] == 0) begin
            v = kv[4];
        end else begin
            v = (f * kv[4]) / kf[4];
        end
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        if (sh_nom == 0) pwm = PWM_FS;
        else pwm = (v * PWM_FS) / sh_nom;
        if (pwm > 65535) pwm = 65535;
        r.volt = v[15:0];
        r.pwm  = pwm[15:0];
        return r;
    endfunction

    // Drop valid for a random idle stretch now and then
    task automatic idle_burst();
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    // Send one frequency beat and queue its expected result
    task automatic send_freq(logic [16:0] fcmd);
        idle_burst();
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, fcmd};
        pending_cmds.push_back(predict_vcmd(fcmd));
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_reg(vfc_pkg::reg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            vfc_pkg::REG_CURVE_MODE: sh_mode = val[0];
            vfc_pkg::REG_MAG_VOLT:   sh_mag  = val[15:0];
            vfc_pkg::REG_KNEE_ONE:   sh_knee[1] = val;
            vfc_pkg::REG_KNEE_TWO:   sh_knee[2] = val;
            vfc_pkg::REG_KNEE_THREE: sh_knee[3] = val;
            vfc_pkg::REG_SAT_KNEE:   sh_knee[4] = val;
            vfc_pkg::REG_NOM_VOLT:   sh_nom  = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_curve(logic mode, logic [15:0] mag, logic [31:0] k1,
                              logic [31:0] k2, logic [31:0] k3, logic [31:0] ks,
                              logic [15:0] nom);
        wait_drained();
        write_reg(vfc_pkg::REG_CURVE_MODE, {31'd0, mode});
        write_reg(vfc_pkg::REG_MAG_VOLT, {16'd0, mag});
        write_reg(vfc_pkg::REG_KNEE_ONE, k1);
        write_reg(vfc_pkg::REG_KNEE_TWO, k2);
        write_reg(vfc_pkg::REG_KNEE_THREE, k3);
        write_reg(vfc_pkg::REG_SAT_KNEE, ks);
        write_reg(vfc_pkg::REG_NOM_VOLT, {16'd0, nom});
        cfg_valid <= 1'b0;
    endtask

    // Frequency biased toward the knee boundaries of the current curve
    function automatic logic [16:0] pick_freq();
        int     k;
        longint f;
        logic [16:0] r;
        case ($urandom_range(0, 3))
            0: f = $urandom_range(0, 65535);
            1: f = $urandom_range(0, 200);
            default: begin
                k = $urandom_range(1, 4);
                f = longint'(sh_knee[k][31:16]) + $urandom_range(0, 4) - 2;
                if (f < 0) f = 0;
                if (f > 65535) f = 65535;
            end
        endcase
        r = f[16:0];
        if ($urandom_range(0, 1)) r = -r;
        return r;
    endfunction

    task automatic random_freqs(int count);
        repeat (count) send_freq(pick_freq());
    endtask

    // Sign and magnitude extremes at the reset curve
    task automatic test_directed_extremes();
        send_freq(17'd0);
        send_freq(17'd1);
        send_freq(17'h1FFFF);
        send_freq(17'd65535);
        send_freq(17'h10001);
        send_freq(17'h10000);
        send_freq(17'd5000);
        send_freq(17'd5001);
        send_freq(-17'sd5000);
        send_freq(17'd2500);
        send_freq(17'h0AAAA);
        send_freq(17'h15555);
    endtask

    // Well-formed piecewise curve, boundaries and zero frequency
    task automatic test_piecewise_boundaries();
        load_curve(1'b1, 16'd200, {16'd1000, 16'd600}, {16'd2500, 16'd1800},
                   {16'd4000, 16'd3000}, {16'd5000, 16'd3800}, 16'd3800);
        foreach (sh_knee[k]) begin
            send_freq(sh_knee[k][31:16] - 17'd1);
            send_freq({1'b0, sh_knee[k][31:16]});
        end
        send_freq(17'd0);
        send_freq(17'd1);
        random_freqs(200);
    endtask

    // Falling segments, overflow clamps and pwm saturation
    task automatic test_falling_and_clamp();
        load_curve(1'b1, 16'd65535, {16'd100, 16'd0}, {16'd200, 16'd65535},
                   {16'd65535, 16'd0}, {16'd30000, 16'd65535}, 16'd1);
        random_freqs(150);
        load_curve(1'b1, 16'd0, {16'd65535, 16'd65535}, {16'd1, 16'd0},
                   {16'd2, 16'd1}, {16'd3, 16'd2}, 16'd65535);
        random_freqs(100);
    endtask

    // Degenerate knees force simple mode and raise the fallback flag; plain simple mode follows
    task automatic test_fallback();
        load_curve(1'b1, 16'd100, {16'd0, 16'd500}, {16'd2000, 16'd900},
                   {16'd3000, 16'd1500}, {16'd5000, 16'd3800}, 16'd0);
        random_freqs(60);
        load_curve(1'b1, 16'd100, {16'd1000, 16'd500}, {16'd1000, 16'd900},
                   {16'd3000, 16'd1500}, {16'd3000, 16'd3800}, 16'd3800);
        random_freqs(60);
        load_curve(1'b0, 16'd0, 32'd0, 32'd0, 32'd0, {16'd0, 16'd4000}, 16'd3800);
        random_freqs(60);
        load_curve(1'b0, 16'd0, 32'd0, 32'd0, 32'd0, 32'hFFFFFFFF, 16'd65535);
        random_freqs(60);
    endtask

    // Output stalls long enough to fill the pipeline, then a full drain
    task automatic test_backpressure();
        load_curve(1'b1, 16'd300, {16'd800, 16'd700}, {16'd1600, 16'd1500},
                   {16'd3200, 16'd2600}, {16'd6000, 16'd4000}, 16'd4000);
        hold_cycles = 300;
        random_freqs(120);
        wait_drained();
        random_freqs(40);
    endtask

    // Random well-formed curves, with occasional raw register noise
    task automatic test_random_curves();
        logic [15:0] fk [1:4];
        for (int set = 0; set < 12; set++) begin
            fk[1] = 16'($urandom_range(1, 16000));
            for (int i = 2; i <= 4; i++) fk[i] = fk[i-1] + 16'($urandom_range(1, 16000));
            if (set % 4 == 3)
                load_curve(1'($urandom_range(0, 1)), 16'($urandom), $urandom, $urandom,
                           $urandom, $urandom, 16'($urandom));
            else
                load_curve(set % 4 != 0, 16'($urandom),
                           {fk[1], 16'($urandom)}, {fk[2], 16'($urandom)},
                           {fk[3], 16'($urandom)}, {fk[4], 16'($urandom)},
                           $urandom_range(0, 3) == 0 ? 16'($urandom) :
                           16'($urandom_range(1, 5000)));
            if (set == 10) quiet_mode = 1;
            random_freqs(60);
        end
    endtask

    // Drive the result ready line with random stalls and a long hold-off
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Compare each accepted result beat with the oldest expected command
    always @(posedge aclk) begin
        vcmd_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected result beat %h/%b", $time, m_tdata, m_tuser);
                n_errors++;
            end else begin
                want = pending_cmds.pop_front();
                n_checked++;
                if (m_tdata[15:0] !== want.volt) begin
                    $display("%0t: voltage_out expected %0d actual %0d",
                             $time, want.volt, m_tdata[15:0]);
                    n_errors++;
                end
                if (m_tdata[31:16] !== want.pwm) begin
                    $display("%0t: pwm_level expected %0d actual %0d",
                             $time, want.pwm, m_tdata[31:16]);
                    n_errors++;
                end
                if (m_tuser !== want.fallback) begin
                    $display("%0t: curve_fallback expected %0b actual %0b",
                             $time, want.fallback, m_tuser);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        n_errors    = 0;
        n_checked   = 0;
        n_sent      = 0;
        quiet_mode  = 0;
        hold_cycles = 0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = vfc_pkg::REG_CURVE_MODE;
        cfg_data    = '0;
        aresetn     = 1'b0;
        sh_mode     = 1'b0;
        sh_mag      = '0;
        sh_knee[1]  = '0;
        sh_knee[2]  = '0;
        sh_knee[3]  = '0;
        sh_knee[4]  = vfc_pkg::SAT_KNEE_RST;
        sh_nom      = vfc_pkg::NOM_VOLT_RST;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_extremes();
        test_piecewise_boundaries();
        test_falling_and_clamp();
        test_fallback();
        test_backpressure();
        test_random_curves();

        wait_drained();
        if (pending_cmds.size() != 0) n_errors++;
        $display("Sent %0d frequency commands, checked %0d results", n_sent, n_checked);
        $display("Covered simple, piecewise, fallback and clamp curves under stalls");
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
`default_nettype wire
